[src/tst_pkg.sv]
`default_nettype none

package tst_pkg;

  localparam int unsigned MAX_FIRES = 64;

  typedef enum logic [1:0] {
    OP_ADD_ONESHOT,
    OP_ADD_PERIODIC,
    OP_CANCEL,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_CANCEL,
    KIND_FIRED,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  timer_id;
    logic         ok;
    logic [31:0]  entry_fires;
    logic [63:0]  total_fire_count;
    logic [6:0]   active_slots;
    logic         last;
  } rsp_t;

  typedef struct packed {
    logic         active;
    logic         periodic;
    logic [31:0]  id;
    logic [31:0]  deadline;
    logic [31:0]  interval;
    logic [31:0]  fires;
  } slot_t;

  typedef struct packed {
    logic fire;
    logic close;
    rsp_t res;
  } resq_cmd_t;

  typedef struct packed {
    logic pend_v;
    logic out_free;
  } resq_sts_t;

endpackage

`default_nettype wire

[src/tst_ifs.sv]
`default_nettype none

interface tst_req_if import tst_pkg::*;;
  logic         valid;
  logic         ready;
  op_t          operation;
  logic [31:0]  now_ms;
  logic [31:0]  delay_ms;
  logic [31:0]  cancel_id;

  modport source (output valid, operation, now_ms, delay_ms, cancel_id, input ready);
  modport sink (input valid, operation, now_ms, delay_ms, cancel_id, output ready);
endinterface

interface tst_rsp_if import tst_pkg::*;;
  logic         valid;
  logic         ready;
  kind_t        result_kind;
  logic [31:0]  timer_id;
  logic         ok;
  logic [31:0]  entry_fires;
  logic [63:0]  total_fire_count;
  logic [6:0]   active_slots;
  logic         last;

  modport source (output valid, result_kind, timer_id, ok, entry_fires, total_fire_count,
                  active_slots, last, input ready);
  modport sink (input valid, result_kind, timer_id, ok, entry_fires, total_fire_count,
                active_slots, last, output ready);
endinterface

`default_nettype wire

[src/tst_resq.sv]
`default_nettype none

module tst_resq import tst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  resq_cmd_t  cmd,
  output resq_sts_t  sts,
  tst_rsp_if.source  rsp
);

  logic  out_v;
  rsp_t  out;
  logic  pend_v;
  rsp_t  pend;
  rsp_t  pend_last;

  assign sts.out_free = !out_v || rsp.ready;
  assign sts.pend_v   = pend_v;

  always_comb begin
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      pend_v <= 1'b0;
    end else if (cmd.close) begin
      out    <= pend_v ? pend_last : cmd.res;
      out_v  <= 1'b1;
      pend_v <= 1'b0;
    end else if (cmd.fire) begin
      pend   <= cmd.res;
      pend_v <= 1'b1;
      if (pend_v) begin
        out   <= pend;
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  assign rsp.valid            = out_v;
  assign rsp.result_kind      = out.kind;
  assign rsp.timer_id         = out.timer_id;
  assign rsp.ok               = out.ok;
  assign rsp.entry_fires      = out.entry_fires;
  assign rsp.total_fire_count = out.total_fire_count;
  assign rsp.active_slots     = out.active_slots;
  assign rsp.last             = out.last;

endmodule

`default_nettype wire

[src/tst_scan.sv]
`default_nettype none

module tst_scan import tst_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tst_req_if.sink    req,
  output resq_cmd_t  cmd,
  input  resq_sts_t  sts
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t              state;
  logic [IDX_W:0]      idx;
  logic                rd_vld;
  logic [IDX_W-1:0]    ev_idx;
  op_t                 op;
  logic [31:0]         now;
  logic [31:0]         delay;
  logic [31:0]         cid;
  logic [31:0]         id_ctr;
  logic [31:0]         id_ctr_next;
  logic [63:0]         total;
  logic [63:0]         total_next;
  logic [CNT_W-1:0]    act_cnt;
  logic [CNT_W-1:0]    act_cnt_next;
  logic [6:0]          nfire;
  logic [6:0]          nfire_next;
  rsp_t                fin;
  rsp_t                fin_next;

  slot_t               mem [SLOTS];
  slot_t               mem_q;
  slot_t               wr_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                rd_en;

  logic                go;
  logic                leave;
  logic                fire;
  logic                last_slot;
  logic [31:0]         diff;
  logic                accept;
  logic                refuse;

  function automatic logic [6:0] sat_act(input logic [CNT_W-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return (w > 32'd127) ? 7'd127 : w[6:0];
  endfunction

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && (state == ST_IDLE);
  assign last_slot = (ev_idx == IDX_W'(SLOTS - 1));
  assign diff      = now - mem_q.deadline;
  assign refuse    = ((req.operation == OP_ADD_PERIODIC) && (req.delay_ms == 32'd0))
                     || (((req.operation == OP_ADD_ONESHOT)
                          || (req.operation == OP_ADD_PERIODIC))
                         && (act_cnt == CNT_W'(SLOTS)));

  always_comb begin
    go           = 1'b0;
    leave        = 1'b0;
    fire         = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = ev_idx;
    wr_data      = mem_q;
    fin_next     = fin;
    id_ctr_next  = id_ctr;
    total_next   = total;
    act_cnt_next = act_cnt;
    nfire_next   = nfire;
    cmd          = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx[IDX_W-1:0];
        wr_data = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          nfire_next = '0;
          if (refuse) begin
            fin_next = '{kind: KIND_ADD, timer_id: 32'd0, ok: 1'b0, entry_fires: 32'd0,
                         total_fire_count: total, active_slots: sat_act(act_cnt),
                         last: 1'b1};
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld) begin
          case (op)
            OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
              go = 1'b1;
              if (!mem_q.active) begin
                wr_en            = 1'b1;
                wr_data.active   = 1'b1;
                wr_data.periodic = (op == OP_ADD_PERIODIC);
                wr_data.id       = id_ctr;
                wr_data.deadline = now + delay;
                wr_data.interval = (op == OP_ADD_PERIODIC) ? delay : 32'd0;
                wr_data.fires    = 32'd0;
                id_ctr_next      = id_ctr + 32'd1;
                act_cnt_next     = act_cnt + CNT_W'(1);
                leave            = 1'b1;
                fin_next         = '{kind: KIND_ADD, timer_id: id_ctr, ok: 1'b1,
                                     entry_fires: 32'd0, total_fire_count: total,
                                     active_slots: sat_act(act_cnt_next), last: 1'b1};
              end
            end
            OP_CANCEL: begin
              go = 1'b1;
              if (mem_q.active && (mem_q.id == cid)) begin
                wr_en          = 1'b1;
                wr_data.active = 1'b0;
                act_cnt_next   = act_cnt - CNT_W'(1);
                leave          = 1'b1;
                fin_next       = '{kind: KIND_CANCEL, timer_id: cid, ok: 1'b1,
                                   entry_fires: 32'd0, total_fire_count: total,
                                   active_slots: sat_act(act_cnt_next), last: 1'b1};
              end else if (last_slot) begin
                leave    = 1'b1;
                fin_next = '{kind: KIND_CANCEL, timer_id: cid, ok: 1'b0,
                             entry_fires: 32'd0, total_fire_count: total,
                             active_slots: sat_act(act_cnt), last: 1'b1};
              end
            end
            OP_TICK: begin
              fire = mem_q.active && !diff[31];
              go   = !(fire && sts.pend_v && !sts.out_free);
              if (go) begin
                if (fire) begin
                  wr_en         = 1'b1;
                  wr_data.fires = mem_q.fires + 32'd1;
                  total_next    = total + 64'd1;
                  nfire_next    = nfire + 7'd1;
                  if (mem_q.periodic) begin
                    wr_data.deadline = now + mem_q.interval;
                  end else begin
                    wr_data.active = 1'b0;
                    act_cnt_next   = act_cnt - CNT_W'(1);
                  end
                  cmd.fire = 1'b1;
                  cmd.res  = '{kind: KIND_FIRED, timer_id: mem_q.id, ok: 1'b1,
                               entry_fires: wr_data.fires, total_fire_count: total_next,
                               active_slots: sat_act(act_cnt_next), last: 1'b0};
                end
                if ((fire && (nfire == 7'(MAX_FIRES - 1))) || last_slot) begin
                  leave    = 1'b1;
                  fin_next = '{kind: KIND_NONE, timer_id: 32'd0, ok: 1'b0,
                               entry_fires: 32'd0, total_fire_count: total_next,
                               active_slots: sat_act(act_cnt_next), last: 1'b1};
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        cmd.close = sts.out_free;
        cmd.res   = fin;
      end
      default: ;
    endcase
  end

  assign rd_en = (state == ST_SCAN) && (idx != (IDX_W + 1)'(SLOTS))
                 && (!rd_vld || go) && !leave;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      rd_vld  <= 1'b0;
      id_ctr  <= 32'd1;
      total   <= 64'd0;
      act_cnt <= '0;
      nfire   <= '0;
    end else begin
      id_ctr  <= id_ctr_next;
      total   <= total_next;
      act_cnt <= act_cnt_next;
      nfire   <= nfire_next;
      fin     <= fin_next;
      case (state)
        ST_CLEAR: begin
          idx <= idx + (IDX_W + 1)'(1);
          if (idx == (IDX_W + 1)'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op     <= req.operation;
            now    <= req.now_ms;
            delay  <= req.delay_ms;
            cid    <= req.cancel_id;
            idx    <= '0;
            rd_vld <= 1'b0;
            if (refuse) begin
              state <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx    <= idx + (IDX_W + 1)'(1);
            ev_idx <= idx[IDX_W-1:0];
          end
          rd_vld <= !leave && (rd_en || (rd_vld && !go));
          if (leave) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    32'(act_cnt) <= SLOTS)
    else $error("active count above table size");

  a_fire_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fire && sts.pend_v |-> sts.out_free)
    else $error("fire pushed with no room for the held result");

  a_close_room: assert property (@(posedge clk) disable iff (rst)
    cmd.close |-> sts.out_free)
    else $error("close pushed while output register is full");

  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    32'(nfire) <= MAX_FIRES)
    else $error("too many fires in one tick");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != idx[IDX_W-1:0])
    else $error("read and write of the same slot in one cycle");

endmodule

`default_nettype wire

[src/timer_slot_table_top.sv]
`default_nettype none

// channel | dir | fields
// req     | in  | operation, now_ms, delay_ms, cancel_id
// rsp     | out | result_kind, timer_id, ok, entry_fires, total_fire_count,
//         |     | active_slots, last
//
// One request at a time; slot reads are registered and the memory is scanned one
// slot per cycle but for the stall below. A missed cancel scans every slot, as does
// a tick below MAX_FIRES fires; an add or a hit cancel stops at the slot it uses;
// a refused add skips the scan. The memory is cleared after reset before req.ready
// rises. A stalled rsp holds a tick scan only when a second fire needs the output.

module timer_slot_table_top import tst_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tst_req_if.sink    req,
  tst_rsp_if.source  rsp
);

  resq_cmd_t cmd;
  resq_sts_t sts;

  tst_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts)
  );

  tst_resq u_resq (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[bench/tb_timer_slot_table_top.sv]
module tb_timer_slot_table_top;
  import tst_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_REQUESTS = 360;
  localparam int DIRECTED_ROWS = 19;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    op_t         op;
    logic [31:0] now_val;
    logic [31:0] delay;
    logic [31:0] cid;
    bit          typed;
    rsp_t        want;
  } step_row_t;

  logic clk;
  logic rst;

  tst_req_if req ();
  tst_rsp_if rsp ();

  timer_slot_table_top #(.SLOTS(SLOTS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic        live [SLOTS];
  logic        repeating [SLOTS];
  logic [31:0] owner_id [SLOTS];
  logic [31:0] due_ms [SLOTS];
  logic [31:0] period_ms [SLOTS];
  logic [31:0] fire_count [SLOTS];
  logic [31:0] next_timer_id;
  logic [63:0] fires_since_reset;
  rsp_t        expected_rsps [$];

  int   errors;
  int   quiet_cycles;
  int   rx_hold;
  bit   rx_greedy;
  bit   tx_burst;
  bit   row_typed;
  rsp_t row_want;

  step_row_t script [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] live_count();
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i]) n++;
    end
    return n;
  endfunction

  function automatic void push_result(kind_t kind, logic [31:0] id, logic ok,
                                      logic [31:0] fires, logic [6:0] active, logic last);
    rsp_t r;
    r = '{kind, id, ok, fires, fires_since_reset, active, last};
    expected_rsps.push_back(r);
  endfunction

  function automatic void predict_request(op_t op, logic [31:0] now_val, logic [31:0] delay,
                                          logic [31:0] cid);
    int          slot;
    int          fired;
    logic [6:0]  active;
    logic [31:0] lag;
    rsp_t        tail;
    slot = 0;
    fired = 0;
    active = live_count();
    case (op)
      OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
        while (slot < SLOTS && live[slot]) slot++;
        if ((op == OP_ADD_PERIODIC && delay == '0) || slot == SLOTS) begin
          push_result(KIND_ADD, '0, 1'b0, '0, active, 1'b1);
        end else begin
          live[slot] = 1'b1;
          repeating[slot] = (op == OP_ADD_PERIODIC);
          owner_id[slot] = next_timer_id;
          due_ms[slot] = now_val + delay;
          period_ms[slot] = (op == OP_ADD_PERIODIC) ? delay : '0;
          fire_count[slot] = '0;
          next_timer_id = next_timer_id + 32'd1;
          push_result(KIND_ADD, owner_id[slot], 1'b1, '0, active + 7'd1, 1'b1);
        end
      end
      OP_CANCEL: begin
        while (slot < SLOTS && !(live[slot] && owner_id[slot] == cid)) slot++;
        if (slot < SLOTS) begin
          live[slot] = 1'b0;
          active = active - 7'd1;
        end
        push_result(KIND_CANCEL, cid, slot < SLOTS, '0, active, 1'b1);
      end
      default: begin
        for (slot = 0; slot < SLOTS && fired < MAX_FIRES; slot++) begin
          lag = now_val - due_ms[slot];
          if (live[slot] && !lag[31]) begin
            fire_count[slot] = fire_count[slot] + 32'd1;
            fires_since_reset = fires_since_reset + 64'd1;
            if (repeating[slot]) begin
              due_ms[slot] = now_val + period_ms[slot];
            end else begin
              live[slot] = 1'b0;
              active = active - 7'd1;
            end
            push_result(KIND_FIRED, owner_id[slot], 1'b1, fire_count[slot], active, 1'b0);
            fired++;
          end
        end
        if (fired == 0) begin
          push_result(KIND_NONE, '0, 1'b0, '0, active, 1'b1);
        end else begin
          tail = expected_rsps.pop_back();
          tail.last = 1'b1;
          expected_rsps.push_back(tail);
        end
      end
    endcase
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: rsp %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(rsp_t want);
    compare_field("result_kind", want.kind, rsp.result_kind);
    compare_field("timer_id", want.timer_id, rsp.timer_id);
    compare_field("ok", want.ok, rsp.ok);
    compare_field("entry_fires", want.entry_fires, rsp.entry_fires);
    compare_field("total_fire_count", want.total_fire_count, rsp.total_fire_count);
    compare_field("active_slots", want.active_slots, rsp.active_slots);
    compare_field("last", want.last, rsp.last);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        predict_request(req.operation, req.now_ms, req.delay_ms, req.cancel_id);
        if (row_typed) begin
          void'(expected_rsps.pop_back());
          expected_rsps.push_back(row_want);
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected rsp, expected none, actual kind %0d id %0h", $time,
                   rsp.result_kind, rsp.timer_id);
        end else begin
          check_result(expected_rsps.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rsp.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_greedy || $urandom_range(0, 99) < 70) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= 1'b0;
      rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(op_t op, logic [31:0] now_val, logic [31:0] delay,
                              logic [31:0] cid, bit typed, rsp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.now_ms <= now_val;
    req.delay_ms <= delay;
    req.cancel_id <= cid;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  initial begin
    int          n;
    int          pick;
    int          start;
    bit          filling;
    op_t         op;
    logic [31:0] clock_ms;
    logic [31:0] now_val;
    logic [31:0] delay;
    logic [31:0] cid;

    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_TICK;
    req.now_ms = '0;
    req.delay_ms = '0;
    req.cancel_id = '0;
    rsp.ready = 1'b0;
    row_typed = 1'b0;
    row_want = '0;
    rx_hold = 0;
    rx_greedy = 1'b0;
    tx_burst = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      repeating[i] = 1'b0;
      owner_id[i] = '0;
      due_ms[i] = '0;
      period_ms[i] = '0;
      fire_count[i] = '0;
    end
    next_timer_id = 32'd1;
    fires_since_reset = '0;

    script = '{
      '{OP_TICK, 32'd0, 32'd0, 32'd0, 1'b1,
        '{KIND_NONE, 32'd0, 1'b0, 32'd0, 64'd0, 7'd0, 1'b1}},
      '{OP_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
        '{KIND_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 64'd0, 7'd0, 1'b1}},
      '{OP_ADD_PERIODIC, 32'd0, 32'd0, 32'd0, 1'b1,
        '{KIND_ADD, 32'd0, 1'b0, 32'd0, 64'd0, 7'd0, 1'b1}},
      '{OP_ADD_ONESHOT, 32'd0, 32'd0, 32'd0, 1'b1,
        '{KIND_ADD, 32'd1, 1'b1, 32'd0, 64'd0, 7'd1, 1'b1}},
      '{OP_TICK, 32'd0, 32'd0, 32'd0, 1'b1,
        '{KIND_FIRED, 32'd1, 1'b1, 32'd1, 64'd1, 7'd0, 1'b1}},
      '{OP_ADD_PERIODIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
      '{OP_ADD_ONESHOT, 32'hFFFF_FFF0, 32'h0000_0020, 32'd0, 1'b0, '0},
      '{OP_ADD_PERIODIC, 32'd0, 32'h8000_0000, 32'd0, 1'b0, '0},
      '{OP_TICK, 32'hFFFF_FFFD, 32'd0, 32'd0, 1'b0, '0},
      '{OP_TICK, 32'h0000_0010, 32'd0, 32'd0, 1'b0, '0},
      '{OP_TICK, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
      '{OP_CANCEL, 32'd0, 32'd0, 32'd2, 1'b0, '0},
      '{OP_CANCEL, 32'd0, 32'd0, 32'd2, 1'b0, '0},
      '{OP_CANCEL, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{OP_ADD_ONESHOT, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 1'b0, '0},
      '{OP_ADD_PERIODIC, 32'hAAAA_AAAA, 32'd1, 32'd0, 1'b0, '0},
      '{OP_TICK, 32'hAAAA_AAAB, 32'd0, 32'd0, 1'b0, '0},
      '{OP_TICK, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
      '{OP_CANCEL, 32'd0, 32'd0, 32'd4, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_request(script[i].op, script[i].now_val, script[i].delay, script[i].cid,
                   script[i].typed, script[i].want);
    end

    // walk the clock across the 32-bit wrap; alternate filling and draining the table
    clock_ms = 32'hFFFF_F000 + $urandom_range(0, 1023);
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 30 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_greedy <= ($urandom_range(0, 3) == 0);
      end
      filling = ((n / 90) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 40) op = OP_ADD_ONESHOT;
        else if (pick < 75) op = OP_ADD_PERIODIC;
        else if (pick < 88) op = OP_TICK;
        else op = OP_CANCEL;
      end else begin
        if (pick < 50) op = OP_TICK;
        else if (pick < 80) op = OP_CANCEL;
        else if (pick < 90) op = OP_ADD_ONESHOT;
        else op = OP_ADD_PERIODIC;
      end

      if (op == OP_TICK) begin
        pick = $urandom_range(0, 99);
        if (filling) clock_ms = clock_ms + $urandom_range(0, 4);
        else if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 300);
        else clock_ms = clock_ms + $urandom_range(1000, 32'h7FFF_0000);
      end
      now_val = ($urandom_range(0, 99) < 8) ? $urandom : clock_ms;

      pick = $urandom_range(0, 99);
      if (pick < 5) delay = '0;
      else if (pick < 85) delay = $urandom_range(1, 400);
      else delay = $urandom;

      cid = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        cid = next_timer_id - $urandom_range(0, 1);
      end else if (pick < 85) begin
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
          if (live[(start + k) % SLOTS]) begin
            cid = owner_id[(start + k) % SLOTS];
            break;
          end
        end
      end

      send_request(op, now_val, delay, cid, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
